// ===== rtl/cac_pkg.sv =====
package cac_pkg;

  // Default sizes of the index table, the record pool and the PC shift.
  localparam int unsigned IndexSlotsDefault = 4096;
  localparam int unsigned PoolDepthDefault  = 1024;
  localparam int unsigned ArcShiftDefault   = 2;

  // Field widths of the result and of the configuration port.
  localparam int unsigned StatusW   = 3;
  localparam int unsigned ArcSlotW  = 10;
  localparam int unsigned CountW    = 32;
  localparam int unsigned PcW       = 32;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 13;
  localparam int unsigned IdxLimitW = 13;
  localparam int unsigned PoolLimW  = 11;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_ENABLE      = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_INDEX_LIMIT = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_POOL_LIMIT  = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [IdxLimitW-1:0] IndexLimitReset = 13'd4096;
  localparam logic [PoolLimW-1:0]  PoolLimitReset  = 11'd1024;

  // Result status codes.
  localparam logic [StatusW-1:0] ST_IDLE  = 3'd0;
  localparam logic [StatusW-1:0] ST_RANGE = 3'd1;
  localparam logic [StatusW-1:0] ST_HEAD  = 3'd2;
  localparam logic [StatusW-1:0] ST_CHAIN = 3'd3;
  localparam logic [StatusW-1:0] ST_COUNT = 3'd4;
  localparam logic [StatusW-1:0] ST_STOP  = 3'd5;
  localparam logic [StatusW-1:0] ST_DROP  = 3'd6;

endpackage

// ===== rtl/call_arc_counter_top.sv =====
// Call-graph arc counter. Each input transaction is one call event (caller PC,
// callee PC); each one yields exactly one result transaction with a status, the
// pool record touched and that record's count. After reset the block first
// sweeps its index table clear, during which no event is taken; configuration
// writes are accepted throughout. The block then works on one event at a time,
// through the states decode and response for an event that is disabled or out
// of range, decode, slot and response for a stop on a full pool, and decode,
// slot, allocate and response for a new chain head. A hit on a record or a
// dropped entry goes from slot through a read and a check state per record
// walked to response, and a new chain entry adds allocate before response.
// A result waits in an output register, so a new event may enter before it is
// taken; the event after that holds in its response state until the register frees.
module call_arc_counter_top #(
  parameter int unsigned INDEX_SLOTS = cac_pkg::IndexSlotsDefault,
  parameter int unsigned POOL_DEPTH  = cac_pkg::PoolDepthDefault,
  parameter int unsigned ARC_SHIFT   = cac_pkg::ArcShiftDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write port
  input  logic                          cfg_we_i,
  input  logic [cac_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [cac_pkg::CfgDataW-1:0]  cfg_data_i,
  // Event channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [cac_pkg::PcW-1:0]       caller_pc_i,
  input  logic [cac_pkg::PcW-1:0]       callee_pc_i,
  // Result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [cac_pkg::StatusW-1:0]   status_o,
  output logic [cac_pkg::ArcSlotW-1:0]  arc_slot_o,
  output logic [cac_pkg::CountW-1:0]    arc_count_o
);

  localparam int unsigned SlotAw   = $clog2(INDEX_SLOTS);
  localparam int unsigned PoolAw   = $clog2(POOL_DEPTH);
  localparam int unsigned NfW      = $clog2(POOL_DEPTH + 1);
  localparam int unsigned LimW     = (NfW > cac_pkg::PoolLimW) ? NfW : cac_pkg::PoolLimW;
  localparam int unsigned RecExtW  = (PoolAw > cac_pkg::ArcSlotW) ? PoolAw : cac_pkg::ArcSlotW;
  localparam int unsigned PcW      = cac_pkg::PcW;
  localparam int unsigned CountW   = cac_pkg::CountW;

  // Sequencer states.
  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_DECODE = 3'd2;
  localparam logic [2:0] S_SLOT   = 3'd3;
  localparam logic [2:0] S_REC_RD = 3'd4;
  localparam logic [2:0] S_REC_CK = 3'd5;
  localparam logic [2:0] S_ALLOC  = 3'd6;
  localparam logic [2:0] S_RESP   = 3'd7;

  // Index table entry: valid bit and head record. Link entry: valid bit and record.
  logic [PoolAw:0]       slot_mem [INDEX_SLOTS];
  logic [PcW-1:0]        callee_mem [POOL_DEPTH];
  logic [CountW-1:0]     count_mem [POOL_DEPTH];
  logic [PoolAw:0]       next_mem [POOL_DEPTH];

  logic [2:0]            state_q, state_d;
  logic [SlotAw-1:0]     clr_q, clr_d;
  logic                  enable_q;
  logic [cac_pkg::IdxLimitW-1:0] index_limit_q;
  logic [cac_pkg::PoolLimW-1:0]  pool_limit_q;
  logic                  stopped_q, stopped_d;
  logic [NfW-1:0]        next_free_q, next_free_d;
  logic [PcW-1:0]        caller_q, caller_d;
  logic [PcW-1:0]        callee_q, callee_d;
  logic [PoolAw-1:0]     rec_q, rec_d;
  logic                  alloc_head_q, alloc_head_d;

  logic [cac_pkg::StatusW-1:0] res_status_q, res_status_d;
  logic [PoolAw-1:0]     res_rec_q, res_rec_d;
  logic [CountW-1:0]     res_count_q, res_count_d;

  logic                  out_valid_q, out_valid_d;
  logic [cac_pkg::StatusW-1:0]  out_status_q, out_status_d;
  logic [cac_pkg::ArcSlotW-1:0] out_slot_q, out_slot_d;
  logic [CountW-1:0]     out_count_q, out_count_d;

  logic [PoolAw:0]       slot_rd_q;
  logic [PcW-1:0]        callee_rd_q;
  logic [CountW-1:0]     count_rd_q;
  logic [PoolAw:0]       next_rd_q;

  // Memory write controls.
  logic                  slot_we;
  logic [SlotAw-1:0]     slot_waddr;
  logic [PoolAw:0]       slot_wdata;
  logic                  callee_we;
  logic                  count_we;
  logic [PoolAw-1:0]     count_waddr;
  logic [CountW-1:0]     count_wdata;
  logic                  next_we;
  logic [PoolAw-1:0]     next_waddr;
  logic [PoolAw:0]       next_wdata;

  logic [PcW-1:0]        idx;
  logic                  out_of_range;
  logic [LimW-1:0]       pool_lim_eff;
  logic                  pool_full;
  logic [PoolAw-1:0]     nf_addr;
  logic [CountW-1:0]     count_inc;
  logic [RecExtW-1:0]    res_rec_ext;

  // Slot index from the caller PC and its range check.
  assign idx          = caller_q >> ARC_SHIFT;
  assign out_of_range = (idx >= PcW'(index_limit_q)) || (idx >= PcW'(INDEX_SLOTS));

  // Allocation bound is the smaller of the pool limit register and the pool depth.
  assign pool_lim_eff = (LimW'(pool_limit_q) < LimW'(POOL_DEPTH)) ?
                        LimW'(pool_limit_q) : LimW'(POOL_DEPTH);
  assign pool_full    = LimW'(next_free_q) >= pool_lim_eff;
  assign nf_addr      = next_free_q[PoolAw-1:0];

  // Saturating increment of the record count.
  assign count_inc    = (count_rd_q == '1) ? count_rd_q : count_rd_q + 1'b1;

  assign res_rec_ext  = RecExtW'(res_rec_q);

  // Sequencer.
  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    stopped_d    = stopped_q;
    next_free_d  = next_free_q;
    caller_d     = caller_q;
    callee_d     = callee_q;
    rec_d        = rec_q;
    alloc_head_d = alloc_head_q;
    res_status_d = res_status_q;
    res_rec_d    = res_rec_q;
    res_count_d  = res_count_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_slot_d   = out_slot_q;
    out_count_d  = out_count_q;
    slot_we      = 1'b0;
    slot_waddr   = idx[SlotAw-1:0];
    slot_wdata   = {1'b1, nf_addr};
    callee_we    = 1'b0;
    count_we     = 1'b0;
    count_waddr  = nf_addr;
    count_wdata  = CountW'(1);
    next_we      = 1'b0;
    next_waddr   = nf_addr;
    next_wdata   = '0;
    in_ready_o   = 1'b0;

    // The output register frees when its transaction is taken.
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_CLEAR: begin
        slot_we    = 1'b1;
        slot_waddr = clr_q;
        slot_wdata = '0;
        clr_d      = clr_q + 1'b1;
        if (clr_q == SlotAw'(INDEX_SLOTS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          caller_d = caller_pc_i;
          callee_d = callee_pc_i;
          state_d  = S_DECODE;
        end
      end
      S_DECODE: begin
        res_rec_d   = '0;
        res_count_d = '0;
        priority if (!enable_q || stopped_q) begin
          res_status_d = cac_pkg::ST_IDLE;
          state_d      = S_RESP;
        end else if (out_of_range) begin
          res_status_d = cac_pkg::ST_RANGE;
          state_d      = S_RESP;
        end else begin
          state_d = S_SLOT;
        end
      end
      S_SLOT: begin
        priority if (slot_rd_q[PoolAw]) begin
          rec_d   = slot_rd_q[PoolAw-1:0];
          state_d = S_REC_RD;
        end else if (pool_full) begin
          stopped_d    = 1'b1;
          res_status_d = cac_pkg::ST_STOP;
          state_d      = S_RESP;
        end else begin
          // New chain head: point the slot at the next free record.
          slot_we      = 1'b1;
          alloc_head_d = 1'b1;
          state_d      = S_ALLOC;
        end
      end
      S_REC_RD: begin
        state_d = S_REC_CK;
      end
      S_REC_CK: begin
        priority if (callee_rd_q == callee_q) begin
          count_we     = 1'b1;
          count_waddr  = rec_q;
          count_wdata  = count_inc;
          res_status_d = cac_pkg::ST_COUNT;
          res_rec_d    = rec_q;
          res_count_d  = count_inc;
          state_d      = S_RESP;
        end else if (next_rd_q[PoolAw]) begin
          rec_d   = next_rd_q[PoolAw-1:0];
          state_d = S_REC_RD;
        end else if (pool_full) begin
          res_status_d = cac_pkg::ST_DROP;
          state_d      = S_RESP;
        end else begin
          // Link the tail to the next free record.
          next_we      = 1'b1;
          next_waddr   = rec_q;
          next_wdata   = {1'b1, nf_addr};
          alloc_head_d = 1'b0;
          state_d      = S_ALLOC;
        end
      end
      S_ALLOC: begin
        callee_we    = 1'b1;
        count_we     = 1'b1;
        next_we      = 1'b1;
        next_free_d  = next_free_q + 1'b1;
        res_status_d = alloc_head_q ? cac_pkg::ST_HEAD : cac_pkg::ST_CHAIN;
        res_rec_d    = nf_addr;
        res_count_d  = CountW'(1);
        state_d      = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_slot_d   = res_rec_ext[cac_pkg::ArcSlotW-1:0];
          out_count_d  = res_count_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // A write of the enable register restarts a stopped block.
    if (cfg_we_i && (cfg_idx_i == cac_pkg::REG_ENABLE)) begin
      stopped_d = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      stopped_q   <= 1'b0;
      next_free_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      stopped_q   <= stopped_d;
      next_free_q <= next_free_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q      <= 1'b0;
      index_limit_q <= cac_pkg::IndexLimitReset;
      pool_limit_q  <= cac_pkg::PoolLimitReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cac_pkg::REG_ENABLE:      enable_q      <= cfg_data_i[0];
        cac_pkg::REG_INDEX_LIMIT: index_limit_q <= cfg_data_i;
        cac_pkg::REG_POOL_LIMIT:  pool_limit_q  <= cfg_data_i[cac_pkg::PoolLimW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    caller_q     <= caller_d;
    callee_q     <= callee_d;
    rec_q        <= rec_d;
    alloc_head_q <= alloc_head_d;
    res_status_q <= res_status_d;
    res_rec_q    <= res_rec_d;
    res_count_q  <= res_count_d;
    out_status_q <= out_status_d;
    out_slot_q   <= out_slot_d;
    out_count_q  <= out_count_d;
  end

  // Index table with registered read.
  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    slot_rd_q <= slot_mem[idx[SlotAw-1:0]];
  end

  // Record pool memories, each read at the current record with registered read.
  always_ff @(posedge clk_i) begin
    if (callee_we) begin
      callee_mem[nf_addr] <= callee_q;
    end
    callee_rd_q <= callee_mem[rec_q];
  end

  always_ff @(posedge clk_i) begin
    if (count_we) begin
      count_mem[count_waddr] <= count_wdata;
    end
    count_rd_q <= count_mem[rec_q];
  end

  always_ff @(posedge clk_i) begin
    if (next_we) begin
      next_mem[next_waddr] <= next_wdata;
    end
    next_rd_q <= next_mem[rec_q];
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign arc_slot_o  = out_slot_q;
  assign arc_count_o = out_count_q;

  // The free pointer never runs past the pool.
  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_free_q <= NfW'(POOL_DEPTH))
    else $error("free pointer beyond pool depth");

  // Each allocation takes exactly one record.
  a_alloc_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ALLOC) |=> (next_free_q == NfW'($past(next_free_q) + 1'b1)))
    else $error("allocation did not advance the free pointer by one");

  // A stopped block allocates nothing.
  a_stopped_no_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stopped_q |-> (state_q != S_ALLOC))
    else $error("allocation while stopped");

  // New records always report a count of one.
  a_new_count_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && ((out_status_q == cac_pkg::ST_HEAD) || (out_status_q == cac_pkg::ST_CHAIN)))
    |-> (out_count_q == CountW'(1)))
    else $error("new record with count other than one");

  // A result enters the output register only from the response state.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_RESP))
    else $error("result loaded outside the response state");

endmodule

// ===== dv/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Slots      = cac_pkg::IndexSlotsDefault;
  localparam int unsigned Depth      = cac_pkg::PoolDepthDefault;
  localparam int unsigned Shift      = cac_pkg::ArcShiftDefault;
  localparam int unsigned StatusW    = cac_pkg::StatusW;
  localparam int unsigned ArcSlotW   = cac_pkg::ArcSlotW;
  localparam int unsigned CountW     = cac_pkg::CountW;
  localparam int unsigned PcW        = cac_pkg::PcW;
  localparam int unsigned CfgIdxW    = cac_pkg::CfgIdxW;
  localparam int unsigned CfgDataW   = cac_pkg::CfgDataW;
  localparam int unsigned IdxLimitW  = cac_pkg::IdxLimitW;
  localparam int unsigned PoolLimW   = cac_pkg::PoolLimW;
  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned HotSlots   = 32;
  localparam int unsigned HotCallees = 8;

  typedef struct packed {
    logic [StatusW-1:0]  status;
    logic [ArcSlotW-1:0] slot;
    logic [CountW-1:0]   count;
  } arc_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [PcW-1:0]      caller_pc_i;
  logic [PcW-1:0]      callee_pc_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [StatusW-1:0]  status_o;
  logic [ArcSlotW-1:0] arc_slot_o;
  logic [CountW-1:0]   arc_count_o;

  call_arc_counter_top i_dut (.*);

  // Shadow copy of the block's configuration and arc tables.
  logic                 cfg_enable;
  logic [IdxLimitW-1:0] cfg_index_limit;
  logic [PoolLimW-1:0]  cfg_pool_limit;
  bit                   head_valid [Slots];
  int unsigned          head_rec   [Slots];
  logic [PcW-1:0]       rec_callee [Depth];
  logic [CountW-1:0]    rec_count  [Depth];
  bit                   rec_linked [Depth];
  int unsigned          rec_link   [Depth];
  int unsigned          free_ptr;
  bit                   halted_full;

  arc_result_t          pending_results [$];
  logic [PcW-1:0]       hot_callee [HotCallees];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned stall_request;
  int unsigned stall_left;
  int unsigned error_count;
  int unsigned cycle_count;

  // Clock generation.
  always #5 clk_i = ~clk_i;

  // Timeout guard.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("call_arc_counter_top: mismatch");
      $finish;
    end
  end

  // The pool is bounded by the smaller of the register and the physical depth.
  function automatic bit pool_exhausted();
    int unsigned bound;
    bound = (cfg_pool_limit < Depth) ? cfg_pool_limit : Depth;
    return free_ptr >= bound;
  endfunction

  function automatic int unsigned take_record(input logic [PcW-1:0] callee);
    int unsigned r;
    r = free_ptr;
    free_ptr++;
    rec_callee[r] = callee;
    rec_count[r]  = 1;
    rec_linked[r] = 1'b0;
    rec_link[r]   = 0;
    return r;
  endfunction

  // Updates the arc tables for one call event and returns the result it yields.
  function automatic arc_result_t tally_call(input logic [PcW-1:0] caller,
                                             input logic [PcW-1:0] callee);
    arc_result_t res;
    int unsigned idx;
    int unsigned rec;
    int unsigned n;
    int unsigned steps;
    res = '0;
    if (!cfg_enable || halted_full) begin
      res.status = cac_pkg::ST_IDLE;
      return res;
    end
    idx = caller >> Shift;
    if (idx >= cfg_index_limit || idx >= Slots) begin
      res.status = cac_pkg::ST_RANGE;
      return res;
    end
    // An empty slot takes a new head record, or halts the block when none is left.
    if (!head_valid[idx]) begin
      if (pool_exhausted()) begin
        halted_full = 1'b1;
        res.status  = cac_pkg::ST_STOP;
        return res;
      end
      rec = take_record(callee);
      head_valid[idx] = 1'b1;
      head_rec[idx]   = rec;
      res.status = cac_pkg::ST_HEAD;
      res.slot   = ArcSlotW'(rec);
      res.count  = 1;
      return res;
    end
    // Walk the chain looking for the callee; append at the tail on a miss.
    rec = head_rec[idx];
    for (steps = 0; steps < Depth && rec < Depth; steps++) begin
      if (rec_callee[rec] == callee) begin
        if (rec_count[rec] != '1) rec_count[rec]++;
        res.status = cac_pkg::ST_COUNT;
        res.slot   = ArcSlotW'(rec);
        res.count  = rec_count[rec];
        return res;
      end
      if (!rec_linked[rec]) begin
        if (pool_exhausted()) begin
          res.status = cac_pkg::ST_DROP;
          return res;
        end
        n = take_record(callee);
        rec_linked[rec] = 1'b1;
        rec_link[rec]   = n;
        res.status = cac_pkg::ST_CHAIN;
        res.slot   = ArcSlotW'(n);
        res.count  = 1;
        return res;
      end
      rec = rec_link[rec];
    end
    res.status = cac_pkg::ST_DROP;
    return res;
  endfunction

  // Prints one line for a mismatch and counts it.
  task automatic report_mismatch(input string what, input logic [CountW-1:0] want,
                                 input logic [CountW-1:0] got);
    error_count++;
    $display("[%0t] ERROR %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
  endtask

  // Result receiver: random idling, with a long hold-off on request.
  always @(negedge clk_i) begin
    if (stall_request != 0) begin
      stall_left    = stall_request;
      stall_request = 0;
    end
    if (stall_left != 0) begin
      stall_left--;
      out_ready_i = 1'b0;
    end else begin
      out_ready_i = ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  // Compare each result transaction with the oldest expected one.
  always @(posedge clk_i) begin
    arc_result_t want;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_ready_i === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with none outstanding, status", '0, status_o);
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status) report_mismatch("status", want.status, status_o);
        if (arc_slot_o !== want.slot) report_mismatch("arc_slot", want.slot, arc_slot_o);
        if (arc_count_o !== want.count) report_mismatch("arc_count", want.count, arc_count_o);
      end
    end
  end

  // Sends one call event and records the result it should produce.
  task automatic send_call(input logic [PcW-1:0] caller, input logic [PcW-1:0] callee);
    while ($urandom_range(99, 0) < send_idle_pct) @(negedge clk_i);
    in_valid_i  = 1'b1;
    caller_pc_i = caller;
    callee_pc_i = callee;
    @(posedge clk_i);
    while (in_ready_o !== 1'b1) @(posedge clk_i);
    pending_results.push_back(tally_call(caller, callee));
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  // Holds the sender until every outstanding result has been taken.
  task automatic wait_for_results();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Register writes happen only with the block idle.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    wait_for_results();
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      cac_pkg::REG_ENABLE: begin
        cfg_enable  = data[0];
        halted_full = 1'b0;
      end
      cac_pkg::REG_INDEX_LIMIT: cfg_index_limit = data[IdxLimitW-1:0];
      cac_pkg::REG_POOL_LIMIT:  cfg_pool_limit  = data[PoolLimW-1:0];
      default: ;
    endcase
  endtask

  // Mostly repeated calls among a few hot slots and callees, so chains form
  // and counts climb; the rest are fresh arcs, window edges and noise.
  task automatic send_random_call();
    int unsigned pick;
    int unsigned edge_idx;
    logic [PcW-1:0] caller;
    logic [PcW-1:0] callee;
    pick = $urandom_range(99, 0);
    if (pick < 75) begin
      caller = ($urandom_range(HotSlots - 1, 0) << Shift) | $urandom_range(3, 0);
      callee = hot_callee[$urandom_range(HotCallees - 1, 0)];
    end else if (pick < 83) begin
      caller = $urandom_range((Slots << Shift) - 1, 0);
      callee = $urandom;
    end else if (pick < 90) begin
      edge_idx = cfg_index_limit - $urandom_range(1, 0);
      caller = (edge_idx << Shift) | $urandom_range(3, 0);
      callee = hot_callee[$urandom_range(HotCallees - 1, 0)];
    end else begin
      caller = $urandom;
      callee = $urandom;
    end
    send_call(caller, callee);
  endtask

  // Picks a new index window, pool bound and enable for the next stretch.
  task automatic pick_settings();
    int unsigned lim;
    logic [CfgDataW-1:0] data;
    case ($urandom_range(3, 0))
      0:       lim = Slots;
      1:       lim = $urandom_range(Slots, 1);
      2:       lim = $urandom_range(HotSlots * 2, 0);
      default: lim = HotSlots / 2;
    endcase
    write_reg(cac_pkg::REG_INDEX_LIMIT, CfgDataW'(lim));
    case ($urandom_range(3, 0))
      0:       lim = $urandom_range(free_ptr, 0);
      1:       lim = free_ptr + $urandom_range(12, 1);
      default: lim = Depth;
    endcase
    if (lim > Depth) lim = Depth;
    write_reg(cac_pkg::REG_POOL_LIMIT, CfgDataW'(lim));
    data    = CfgDataW'($urandom);
    data[0] = ($urandom_range(9, 0) != 0);
    write_reg(cac_pkg::REG_ENABLE, data);
  endtask

  // Disabled events, head/chain/count, window edges, halt on a full pool,
  // restart and dropped chain entries.
  task automatic test_directed_cases();
    send_call(32'h0000_0000, 32'h0000_1234);
    write_reg(cac_pkg::REG_ENABLE, 13'd1);
    send_call(32'h0000_0003, 32'h0000_0000);
    send_call(32'h0000_0003, 32'h0000_0000);
    send_call(32'h0000_0001, 32'hFFFF_FFFF);
    send_call(32'h0000_0002, 32'hFFFF_FFFF);
    send_call(32'h0000_0002, 32'h5555_5555);
    send_call(((Slots - 1) << Shift) | 3, 32'hAAAA_AAAA);
    send_call(Slots << Shift, 32'h0000_0001);
    send_call(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    write_reg(cac_pkg::REG_INDEX_LIMIT, 13'd1);
    send_call(32'h0000_0004, 32'h0000_0000);
    send_call(32'h0000_0000, 32'h0000_0000);
    write_reg(cac_pkg::REG_INDEX_LIMIT, 13'd0);
    send_call(32'h0000_0000, 32'h0000_0000);
    write_reg(cac_pkg::REG_INDEX_LIMIT, CfgDataW'(Slots));
    write_reg(cac_pkg::REG_POOL_LIMIT, 13'd0);
    send_call(32'h0000_0008, 32'h0000_0001);
    send_call(32'h0000_0000, 32'h0000_0000);
    write_reg(cac_pkg::REG_ENABLE, 13'd1);
    send_call(32'h0000_0000, 32'h0000_0000);
    send_call(32'h0000_0000, 32'h0000_0007);
    write_reg(cac_pkg::REG_POOL_LIMIT, CfgDataW'(Depth));
    send_call(32'h0000_0000, 32'h0000_0007);
    send_call(32'h0000_0008, 32'h0000_0001);
    write_reg(cac_pkg::REG_ENABLE, 13'd0);
    send_call(32'h0000_0000, 32'h0000_0000);
    write_reg(cac_pkg::REG_ENABLE, 13'd1);
  endtask

  // Receiver holds off long enough for the block to stall its input.
  task automatic test_result_backpressure();
    wait_for_results();
    send_idle_pct = 0;
    stall_request = 150;
    repeat (12) send_random_call();
    wait_for_results();
  endtask

  task automatic test_random_traffic(input int unsigned sender_pct,
                                     input int unsigned receiver_pct,
                                     input int unsigned items);
    int unsigned i;
    wait_for_results();
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    for (i = 0; i < items; i++) begin
      if (i % 60 == 0) pick_settings();
      send_random_call();
    end
  endtask

  // With the pool register above the physical depth, fresh slots fill the
  // pool until the block halts; then restart it and run hits, drops and halts.
  task automatic test_pool_depth_bound();
    int unsigned idx;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(cac_pkg::REG_INDEX_LIMIT, CfgDataW'(Slots));
    write_reg(cac_pkg::REG_POOL_LIMIT, '1);
    write_reg(cac_pkg::REG_ENABLE, 13'd1);
    idx = Slots - 1;
    while (!halted_full && idx > HotSlots) begin
      if (!head_valid[idx]) send_call((idx << Shift) | $urandom_range(3, 0), $urandom);
      idx--;
    end
    repeat (2) send_random_call();
    write_reg(cac_pkg::REG_ENABLE, 13'd1);
    repeat (14) send_random_call();
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    caller_pc_i   = '0;
    callee_pc_i   = '0;
    out_ready_i   = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_request = 0;
    stall_left    = 0;
    error_count   = 0;
    cycle_count   = 0;

    // Shadow state matches the block after reset.
    cfg_enable      = 1'b0;
    cfg_index_limit = cac_pkg::IndexLimitReset;
    cfg_pool_limit  = cac_pkg::PoolLimitReset;
    free_ptr        = 0;
    halted_full     = 1'b0;
    foreach (hot_callee[i]) hot_callee[i] = $urandom;

    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_cases();
    test_result_backpressure();
    test_random_traffic(20, 46, 300);
    test_random_traffic(46, 20, 300);
    test_random_traffic(0, 0, 300);
    test_pool_depth_bound();

    wait_for_results();
    repeat (30) @(posedge clk_i);
    if (error_count == 0) begin
      $display("call_arc_counter_top: match");
    end else begin
      $display("call_arc_counter_top: mismatch");
    end
    $finish;
  end

endmodule
